// ----- rtl/core/orsat_pkg.sv -----
// Shared constants of the oriented rectangle overlap unit and its checker.
package orsat_pkg;

  // Geometry of one pair: two rectangles of three given corners in two dimensions
  localparam int unsigned NUM_RECTS = 2;
  localparam int unsigned NUM_PTS   = 3;
  localparam int unsigned NUM_DIMS  = 2;
  localparam int unsigned NUM_AXES  = 4;
  localparam int unsigned NUM_FIELDS = NUM_RECTS * NUM_PTS * NUM_DIMS;

  // Dimension selectors
  localparam int unsigned DIM_X = 0;
  localparam int unsigned DIM_Y = 1;

  // Register stages from input beat to result register
  localparam int unsigned NUM_STAGES = 6;

  // Result beat: hit in bit 0, padded to one byte
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned HIT_BIT     = 0;

endpackage

// ----- rtl/core/oriented_rect_overlap_sat_unit.sv -----
// Separating-axis overlap test of two oriented rectangles, six-stage pipeline.
//
// One pair of rectangles enters per input beat and one hit flag leaves per
// result beat; with the result side ready the unit takes a pair every cycle
// and delivers its flag from the result register. The six register stages
// are: input corners and edge normals, the 48 coordinate products (four axes
// times six given corners times two dimensions), dot-product sums, the fourth
// corner's projection by linearity (p0 + p2 - p1), per-rectangle min/max,
// and the overlap compare that fills the result register. Each stage holds a
// valid bit; a stage advances when it is empty or the stage after it moves,
// so bubbles close up while a result waits. Touching or a zero-length edge
// gives no hit.
module oriented_rect_overlap_sat_unit #(
  parameter int unsigned COORD_WIDTH = 20
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  // in_tdata, lowest bit up: a_corner0_x, a_corner0_y, a_corner1_x, a_corner1_y,
  // a_corner2_x, a_corner2_y, b_corner0_x, b_corner0_y, b_corner1_x,
  // b_corner1_y, b_corner2_x, b_corner2_y, zero pad to whole bytes
  input  logic                                            in_tvalid,
  output logic                                            in_tready,
  input  logic [((orsat_pkg::NUM_FIELDS*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // out_tdata, lowest bit up: hit, zero pad
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  output logic [orsat_pkg::OUT_TDATA_W-1:0]               out_tdata
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned NW = W + 1;      // edge normal component
  localparam int unsigned MW = 2 * W + 1;  // one coordinate product
  localparam int unsigned PW = 2 * W + 2;  // projection of a given corner
  localparam int unsigned XW = 2 * W + 4;  // projection incl. derived corner
  localparam int unsigned NS = orsat_pkg::NUM_STAGES;
  localparam int unsigned NR = orsat_pkg::NUM_RECTS;
  localparam int unsigned NP = orsat_pkg::NUM_PTS;
  localparam int unsigned ND = orsat_pkg::NUM_DIMS;
  localparam int unsigned NA = orsat_pkg::NUM_AXES;
  localparam int unsigned DX = orsat_pkg::DIM_X;
  localparam int unsigned DY = orsat_pkg::DIM_Y;

  typedef logic signed [W-1:0]  crd_t;
  typedef logic signed [NW-1:0] nrm_t;
  typedef logic signed [MW-1:0] prd_t;
  typedef logic signed [PW-1:0] prj_t;
  typedef logic signed [XW-1:0] ext_t;

  // Stage valid bits and advance enables
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] en;

  // Stage 1: corners and edge normals
  crd_t corner_r   [NR][NP][ND];
  crd_t corner_nxt [NR][NP][ND];
  nrm_t axis_r     [NA][ND];
  nrm_t axis_nxt   [NA][ND];
  // Stage 2: products
  prd_t prod_r     [NA][NR][NP][ND];
  prd_t prod_nxt   [NA][NR][NP][ND];
  // Stage 3: projections of the given corners
  prj_t proj_r     [NA][NR][NP];
  prj_t proj_nxt   [NA][NR][NP];
  // Stage 4: projections of all four corners
  ext_t ext_r      [NA][NR][NP+1];
  ext_t ext_nxt    [NA][NR][NP+1];
  // Stage 5: extent of each rectangle on each axis
  ext_t lo_r       [NA][NR];
  ext_t lo_nxt     [NA][NR];
  ext_t hi_r       [NA][NR];
  ext_t hi_nxt     [NA][NR];
  // Stage 6: result
  logic hit_r;
  logic hit_nxt;

  // Advance a stage when it is empty or the next one moves
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < NS; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage 1: unpack corners, form normals (-(p.y - q.y), p.x - q.x)
  always_comb begin
    for (int r = 0; r < NR; r++) begin
      for (int c = 0; c < NP; c++) begin
        for (int d = 0; d < ND; d++) begin
          corner_nxt[r][c][d] = in_tdata[((r*NP + c)*ND + d)*W +: W];
        end
      end
    end
    for (int r = 0; r < NR; r++) begin
      for (int k = 0; k < 2; k++) begin
        axis_nxt[r*2+k][DX] = nrm_t'(corner_nxt[r][k+1][DY]) - nrm_t'(corner_nxt[r][k][DY]);
        axis_nxt[r*2+k][DY] = nrm_t'(corner_nxt[r][k][DX]) - nrm_t'(corner_nxt[r][k+1][DX]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      corner_r <= corner_nxt;
      axis_r   <= axis_nxt;
    end
  end

  // Stage 2: multiply each normal component by each corner coordinate
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      for (int r = 0; r < NR; r++) begin
        for (int c = 0; c < NP; c++) begin
          for (int d = 0; d < ND; d++) begin
            prod_nxt[a][r][c][d] = prd_t'(axis_r[a][d]) * prd_t'(corner_r[r][c][d]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_r <= prod_nxt;
    end
  end

  // Stage 3: sum the two products into a dot product
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      for (int r = 0; r < NR; r++) begin
        for (int c = 0; c < NP; c++) begin
          proj_nxt[a][r][c] = prj_t'(prod_r[a][r][c][DX]) + prj_t'(prod_r[a][r][c][DY]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      proj_r <= proj_nxt;
    end
  end

  // Stage 4: fourth corner c0 + c2 - c1 projects to p0 + p2 - p1
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      for (int r = 0; r < NR; r++) begin
        for (int c = 0; c < NP; c++) begin
          ext_nxt[a][r][c] = ext_t'(proj_r[a][r][c]);
        end
        ext_nxt[a][r][NP] = ext_t'(proj_r[a][r][0]) + ext_t'(proj_r[a][r][2])
                          - ext_t'(proj_r[a][r][1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ext_r <= ext_nxt;
    end
  end

  // Stage 5: min and max of four projections by a two-level tree
  always_comb begin
    ext_t mn01;
    ext_t mn23;
    ext_t mx01;
    ext_t mx23;
    for (int a = 0; a < NA; a++) begin
      for (int r = 0; r < NR; r++) begin
        mn01 = (ext_r[a][r][1] < ext_r[a][r][0]) ? ext_r[a][r][1] : ext_r[a][r][0];
        mx01 = (ext_r[a][r][0] < ext_r[a][r][1]) ? ext_r[a][r][1] : ext_r[a][r][0];
        mn23 = (ext_r[a][r][3] < ext_r[a][r][2]) ? ext_r[a][r][3] : ext_r[a][r][2];
        mx23 = (ext_r[a][r][2] < ext_r[a][r][3]) ? ext_r[a][r][3] : ext_r[a][r][2];
        lo_nxt[a][r] = (mn23 < mn01) ? mn23 : mn01;
        hi_nxt[a][r] = (mx01 < mx23) ? mx23 : mx01;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  // Stage 6: strict overlap on every axis
  always_comb begin
    ext_t top;
    ext_t bot;
    hit_nxt = 1'b1;
    for (int a = 0; a < NA; a++) begin
      top = (hi_r[a][0] < hi_r[a][1]) ? hi_r[a][0] : hi_r[a][1];
      bot = (lo_r[a][0] < lo_r[a][1]) ? lo_r[a][1] : lo_r[a][0];
      if (!(bot < top)) begin
        hit_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      hit_r <= hit_nxt;
    end
  end

  // Ports
  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];

  always_comb begin
    out_tdata = '0;
    out_tdata[orsat_pkg::HIT_BIT] = hit_r;
  end

endmodule

// ----- rtl/core/orsat_checker.sv -----
// Port-level checker for the oriented rectangle overlap unit, with its bind.
module orsat_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [orsat_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned CW = $clog2(orsat_pkg::NUM_STAGES + 1);

  logic          acc_in;
  logic          acc_out;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  assign acc_in  = in_tvalid && in_tready;
  assign acc_out = out_tvalid && out_tready;

  // Track pairs accepted but not yet delivered
  always_comb begin
    cnt_nxt = cnt_r;
    if (acc_in && !acc_out) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!acc_in && acc_out) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Refuse input only when every stage is full behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input refused without a stalled result");

  // Deliver an accepted pair through the full pipeline when the result side keeps up
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in ##1 out_tready ##1 out_tready ##1 out_tready ##1 out_tready
    ##1 out_tready |=> out_tvalid)
    else $error("result missing after full pipeline latency");

  // Never show a result without a pair in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != '0)
    else $error("result beat without an accepted pair");

  // Never hold more pairs than there are stages
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(orsat_pkg::NUM_STAGES))
    else $error("more pairs in flight than stages");

endmodule

bind oriented_rect_overlap_sat_unit orsat_checker u_orsat_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
